@@ hw/rtl/acbs_pkg.sv @@
// Shared types, codes and helper functions for the alarm clock core.
`default_nettype none

package acbs_pkg;

  // Number of keypad digits in one time entry (HHMMSS)
  localparam int unsigned ENTRY_DIGITS = 6;

  // Keypad codes
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_SET_TIME  = 4'd10;
  localparam logic [3:0] KEY_SET_ALARM = 4'd11;
  localparam logic [3:0] KEY_CANCEL    = 4'd12;
  localparam logic [3:0] KEY_CONFIRM   = 4'd13;
  localparam logic [3:0] KEY_BACKSPACE = 4'd14;
  localparam logic [3:0] KEY_ALARM_TOG = 4'd15;

  // Configuration register indexes
  localparam logic [1:0] REG_TICKS_PER_SEC = 2'd0;
  localparam logic [1:0] REG_TONE_HALF     = 2'd1;
  localparam logic [1:0] REG_BEEP_ON       = 2'd2;
  localparam logic [1:0] REG_BEEP_OFF      = 2'd3;

  // User interface mode
  typedef enum logic [1:0] {
    MODE_CLOCK      = 2'd0,
    MODE_EDIT_TIME  = 2'd1,
    MODE_EDIT_ALARM = 2'd2
  } ui_mode_t;

  // Buzzer sequencer mode
  typedef enum logic [1:0] {
    BUZ_OFF  = 2'd0,
    BUZ_BEEP = 2'd1,
    BUZ_RING = 2'd2
  } sounder_mode_t;

  // Sound requests raised during one tick, applied in this order:
  // beep restart, stop, sequencer step, alarm ring start
  typedef struct packed {
    logic       beep;
    logic [1:0] beep_count;
    logic       stop;
    logic       ring;
  } buz_req_t;

  // Two decimal digits of a value below 64
  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] units;
  } bcd_pair_t;

  function automatic bcd_pair_t bcd_split(input logic [5:0] v);
    bcd_pair_t  r;
    logic [2:0] q;
    logic [5:0] q_x10;
    if (v >= 6'd60)      q = 3'd6;
    else if (v >= 6'd50) q = 3'd5;
    else if (v >= 6'd40) q = 3'd4;
    else if (v >= 6'd30) q = 3'd3;
    else if (v >= 6'd20) q = 3'd2;
    else if (v >= 6'd10) q = 3'd1;
    else                 q = 3'd0;
    q_x10   = {q, 3'b000} - {2'b00, q, 1'b0} + {2'b00, q, 1'b0} + {2'b00, q, 1'b0};
    r.tens  = {1'b0, q};
    r.units = 4'(v - q_x10);
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/acbs_buzzer.sv @@
// Buzzer sequencer: short beep bursts, one-shot alarm ring and tone divider.
`default_nettype none

module acbs_buzzer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire acbs_pkg::buz_req_t req,
  input  wire logic [15:0]       ticks_per_second,
  input  wire logic [7:0]        tone_half_period,
  input  wire logic [15:0]       beep_on_ticks,
  input  wire logic [15:0]       beep_off_ticks,
  output logic                   pin_nxt
);

  typedef struct packed {
    logic [7:0] div;
    logic       pin;
  } tone_t;

  acbs_pkg::sounder_mode_t mode_r, mode_nxt;
  logic [7:0]          tone_div_r, tone_div_nxt;
  logic [1:0]          beeps_left_r, beeps_left_nxt;
  logic                phase_on_r, phase_on_nxt;
  logic [15:0]         beep_cnt_r, beep_cnt_nxt;
  logic [15:0]         ring_cnt_r, ring_cnt_nxt;
  logic                pin_r;

  // Advance the tone divider; toggle the pin when it reaches the half period
  function automatic tone_t tone_advance(input logic [7:0] div, input logic pin,
                                         input logic [7:0] half);
    tone_t t;
    t.div = div + 8'd1;
    t.pin = pin;
    if (t.div >= half) begin
      t.div = 8'd0;
      t.pin = ~pin;
    end
    return t;
  endfunction

  // Next state of the sequencer for one tick
  always_comb begin
    tone_t t;
    mode_nxt       = mode_r;
    tone_div_nxt   = tone_div_r;
    beeps_left_nxt = beeps_left_r;
    phase_on_nxt   = phase_on_r;
    beep_cnt_nxt   = beep_cnt_r;
    ring_cnt_nxt   = ring_cnt_r;
    pin_nxt        = pin_r;
    t              = '0;
    if (step) begin
      // restart a beep burst
      if (req.beep) begin
        mode_nxt       = acbs_pkg::BUZ_BEEP;
        beeps_left_nxt = req.beep_count;
        phase_on_nxt   = 1'b1;
        beep_cnt_nxt   = 16'd0;
        tone_div_nxt   = 8'd0;
      end
      // silence everything
      if (req.stop) begin
        mode_nxt       = acbs_pkg::BUZ_OFF;
        beeps_left_nxt = 2'd0;
        phase_on_nxt   = 1'b0;
        beep_cnt_nxt   = 16'd0;
        ring_cnt_nxt   = 16'd0;
        pin_nxt        = 1'b0;
      end
      unique case (mode_nxt)
        acbs_pkg::BUZ_RING: begin
          t            = tone_advance(tone_div_nxt, pin_nxt, tone_half_period);
          tone_div_nxt = t.div;
          pin_nxt      = t.pin;
          ring_cnt_nxt = ring_cnt_nxt + 16'd1;
          if (ring_cnt_nxt >= ticks_per_second) begin
            mode_nxt       = acbs_pkg::BUZ_OFF;
            beeps_left_nxt = 2'd0;
            phase_on_nxt   = 1'b0;
            beep_cnt_nxt   = 16'd0;
            ring_cnt_nxt   = 16'd0;
            pin_nxt        = 1'b0;
          end
        end
        acbs_pkg::BUZ_BEEP: begin
          if (beeps_left_nxt == 2'd0) begin
            mode_nxt     = acbs_pkg::BUZ_OFF;
            phase_on_nxt = 1'b0;
            beep_cnt_nxt = 16'd0;
            ring_cnt_nxt = 16'd0;
            pin_nxt      = 1'b0;
          end else begin
            beep_cnt_nxt = beep_cnt_nxt + 16'd1;
            if (phase_on_nxt) begin
              t            = tone_advance(tone_div_nxt, pin_nxt, tone_half_period);
              tone_div_nxt = t.div;
              pin_nxt      = t.pin;
              if (beep_cnt_nxt >= beep_on_ticks) begin
                phase_on_nxt = 1'b0;
                beep_cnt_nxt = 16'd0;
                pin_nxt      = 1'b0;
              end
            end else if (beep_cnt_nxt >= beep_off_ticks) begin
              phase_on_nxt   = 1'b1;
              beep_cnt_nxt   = 16'd0;
              beeps_left_nxt = beeps_left_nxt - 2'd1;
            end
          end
        end
        default: begin
        end
      endcase
      // alarm ring takes over whatever was sounding
      if (req.ring) begin
        mode_nxt     = acbs_pkg::BUZ_RING;
        ring_cnt_nxt = 16'd0;
        tone_div_nxt = 8'd0;
      end
    end
  end

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= acbs_pkg::BUZ_OFF;
      tone_div_r   <= 8'd0;
      beeps_left_r <= 2'd0;
      phase_on_r   <= 1'b0;
      beep_cnt_r   <= 16'd0;
      ring_cnt_r   <= 16'd0;
      pin_r        <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      tone_div_r   <= tone_div_nxt;
      beeps_left_r <= beeps_left_nxt;
      phase_on_r   <= phase_on_nxt;
      beep_cnt_r   <= beep_cnt_nxt;
      ring_cnt_r   <= ring_cnt_nxt;
      pin_r        <= pin_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/alarm_clock_with_beep_sequencer_core.sv @@
// Alarm clock core: keypad entry, timekeeping, alarm and buzzer sequencing per tick.
//
// Usage: every transfer on the in_ channel is one loop tick, optionally carrying
// a key press (in_key_valid/in_key_code) and a format button press. Each tick
// yields exactly one transfer on the out_ channel: six display digits, buzzer
// pin level, UI mode, alarm enable and 12/24-hour format.
// A tick taken at a clock edge is presented on out_ in the following cycle.
// Throughput: one tick per cycle while no result is held; the whole tick is evaluated in one pass of
// logic between the state registers and the output register.
// The out_ stage is a single register: the input is stalled only while a result
// is held and out_stall is high; a held result keeps its value until taken.
// Configuration (cfg_index 0..3: ticks per second, tone half period, beep on
// ticks, beep off ticks) is written with cfg_valid; cfg_ready is always high.
// Write it only while no tick is in flight.
// Reset (rst_n low at a clock edge): time 12:45:00, alarm 06:00:00 enabled,
// 24-hour format, normal mode, buzzer silent, registers at default values.
`default_nettype none

module alarm_clock_with_beep_sequencer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // tick channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_key_valid,
  input  wire logic [3:0]  in_key_code,
  input  wire logic        in_button_press,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_digit_0,
  output logic [3:0]       out_digit_1,
  output logic [3:0]       out_digit_2,
  output logic [3:0]       out_digit_3,
  output logic [3:0]       out_digit_4,
  output logic [3:0]       out_digit_5,
  output logic             out_buzzer_level,
  output logic [1:0]       out_ui_mode,
  output logic             out_alarm_on,
  output logic             out_format_24h,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned LenW = $clog2(acbs_pkg::ENTRY_DIGITS + 1);

  // configuration registers
  logic [15:0] ticks_per_sec_r;
  logic [7:0]  tone_half_r;
  logic [15:0] beep_on_r;
  logic [15:0] beep_off_r;

  // clock, alarm and entry state
  logic [4:0]          hours_r, hours_nxt;
  logic [5:0]          minutes_r, minutes_nxt;
  logic [5:0]          seconds_r, seconds_nxt;
  logic [15:0]         sec_acc_r, sec_acc_nxt;
  acbs_pkg::ui_mode_t  ui_r, ui_nxt;
  logic [3:0]          entry_r [acbs_pkg::ENTRY_DIGITS];
  logic [3:0]          entry_nxt [acbs_pkg::ENTRY_DIGITS];
  logic [LenW-1:0]     len_r, len_nxt;
  logic [4:0]          al_hours_r, al_hours_nxt;
  logic [5:0]          al_minutes_r, al_minutes_nxt;
  logic [5:0]          al_seconds_r, al_seconds_nxt;
  logic                al_en_r, al_en_nxt;
  logic                al_fired_r, al_fired_nxt;
  logic                fmt24_r, fmt24_nxt;

  logic                in_xfer;
  acbs_pkg::buz_req_t  buz_req;
  logic                pin_nxt;
  logic [3:0]          disp [acbs_pkg::ENTRY_DIGITS];

  // output stage
  logic       out_valid_r;
  logic [3:0] digit_r [acbs_pkg::ENTRY_DIGITS];
  logic       buzzer_r;
  logic [1:0] ui_out_r;
  logic       alarm_on_r;
  logic       fmt24_out_r;

  // handshake: stall only while a held result is not taken
  assign in_stall  = out_valid_r & out_stall;
  assign in_xfer   = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_per_sec_r <= 16'd1100;
      tone_half_r     <= 8'd3;
      beep_on_r       <= 16'd120;
      beep_off_r      <= 16'd90;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        acbs_pkg::REG_TICKS_PER_SEC: ticks_per_sec_r <= cfg_data;
        acbs_pkg::REG_TONE_HALF:     tone_half_r     <= cfg_data[7:0];
        acbs_pkg::REG_BEEP_ON:       beep_on_r       <= cfg_data;
        acbs_pkg::REG_BEEP_OFF:      beep_off_r      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // One tick: button, key, display, then clock advance
  always_comb begin
    logic [6:0]         ent_h;
    logic [6:0]         ent_m;
    logic [6:0]         ent_s;
    logic [4:0]         disp_h;
    logic               match;
    acbs_pkg::bcd_pair_t bp_h;
    acbs_pkg::bcd_pair_t bp_m;
    acbs_pkg::bcd_pair_t bp_s;

    hours_nxt      = hours_r;
    minutes_nxt    = minutes_r;
    seconds_nxt    = seconds_r;
    sec_acc_nxt    = sec_acc_r;
    ui_nxt         = ui_r;
    entry_nxt      = entry_r;
    len_nxt        = len_r;
    al_hours_nxt   = al_hours_r;
    al_minutes_nxt = al_minutes_r;
    al_seconds_nxt = al_seconds_r;
    al_en_nxt      = al_en_r;
    al_fired_nxt   = al_fired_r;
    fmt24_nxt      = fmt24_r;
    buz_req        = '0;

    // entry decoded as HH MM SS
    ent_h = {3'b000, entry_r[0]} * 7'd10 + {3'b000, entry_r[1]};
    ent_m = {3'b000, entry_r[2]} * 7'd10 + {3'b000, entry_r[3]};
    ent_s = {3'b000, entry_r[4]} * 7'd10 + {3'b000, entry_r[5]};

    if (in_xfer) begin
      // format button
      if (in_button_press) begin
        fmt24_nxt          = ~fmt24_r;
        buz_req.beep       = 1'b1;
        buz_req.beep_count = 2'd1;
      end

      // key handling
      if (in_key_valid) begin
        if (ui_r == acbs_pkg::MODE_CLOCK) begin
          case (in_key_code)
            acbs_pkg::KEY_ALARM_TOG: begin
              al_en_nxt          = ~al_en_r;
              buz_req.beep       = 1'b1;
              buz_req.beep_count = 2'd1;
              buz_req.stop       = al_en_r;
            end
            acbs_pkg::KEY_SET_TIME, acbs_pkg::KEY_SET_ALARM: begin
              ui_nxt             = (in_key_code == acbs_pkg::KEY_SET_TIME) ?
                                   acbs_pkg::MODE_EDIT_TIME : acbs_pkg::MODE_EDIT_ALARM;
              len_nxt            = '0;
              buz_req.beep       = 1'b1;
              buz_req.beep_count = 2'd1;
            end
            default: begin
            end
          endcase
        end else if (in_key_code <= acbs_pkg::KEY_DIGIT_MAX) begin
          // append a digit while there is room
          if (len_r < LenW'(acbs_pkg::ENTRY_DIGITS)) begin
            entry_nxt[len_r] = in_key_code;
            len_nxt          = len_r + LenW'(1);
          end
        end else begin
          case (in_key_code)
            acbs_pkg::KEY_CANCEL: begin
              ui_nxt             = acbs_pkg::MODE_CLOCK;
              len_nxt            = '0;
              buz_req.beep       = 1'b1;
              buz_req.beep_count = 2'd1;
            end
            acbs_pkg::KEY_BACKSPACE: begin
              if (len_r != '0) len_nxt = len_r - LenW'(1);
              buz_req.beep       = 1'b1;
              buz_req.beep_count = 2'd1;
            end
            acbs_pkg::KEY_CONFIRM: begin
              buz_req.beep       = 1'b1;
              buz_req.beep_count = 2'd3;
              if (len_r == LenW'(acbs_pkg::ENTRY_DIGITS)) begin
                len_nxt = '0;
                if (ent_h <= 7'd23 && ent_m <= 7'd59 && ent_s <= 7'd59) begin
                  if (ui_r == acbs_pkg::MODE_EDIT_TIME) begin
                    hours_nxt   = ent_h[4:0];
                    minutes_nxt = ent_m[5:0];
                    seconds_nxt = ent_s[5:0];
                  end else begin
                    al_hours_nxt   = ent_h[4:0];
                    al_minutes_nxt = ent_m[5:0];
                    al_seconds_nxt = ent_s[5:0];
                    al_en_nxt      = 1'b1;
                  end
                  ui_nxt             = acbs_pkg::MODE_CLOCK;
                  buz_req.beep_count = 2'd2;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
    end

    // display digits after the key, before the clock advances
    disp_h = hours_nxt;
    if (!fmt24_nxt) begin
      if (hours_nxt >= 5'd12) disp_h = hours_nxt - 5'd12;
      if (disp_h == 5'd0)     disp_h = 5'd12;
    end
    bp_h = acbs_pkg::bcd_split({1'b0, disp_h});
    bp_m = acbs_pkg::bcd_split(minutes_nxt);
    bp_s = acbs_pkg::bcd_split(seconds_nxt);
    if (ui_nxt != acbs_pkg::MODE_CLOCK) begin
      for (int i = 0; i < acbs_pkg::ENTRY_DIGITS; i++) begin
        disp[i] = (LenW'(i) < len_nxt) ? entry_nxt[i] : 4'd0;
      end
    end else begin
      disp[0] = bp_h.tens;
      disp[1] = bp_h.units;
      disp[2] = bp_m.tens;
      disp[3] = bp_m.units;
      disp[4] = bp_s.tens;
      disp[5] = bp_s.units;
    end

    // advance the clock and check the alarm in normal mode
    match = 1'b0;
    if (in_xfer && ui_nxt == acbs_pkg::MODE_CLOCK) begin
      sec_acc_nxt = sec_acc_r + 16'd1;
      if (sec_acc_nxt >= ticks_per_sec_r) begin
        sec_acc_nxt = 16'd0;
        if (seconds_nxt == 6'd59) begin
          seconds_nxt = 6'd0;
          if (minutes_nxt == 6'd59) begin
            minutes_nxt = 6'd0;
            hours_nxt   = (hours_nxt == 5'd23) ? 5'd0 : hours_nxt + 5'd1;
          end else begin
            minutes_nxt = minutes_nxt + 6'd1;
          end
        end else begin
          seconds_nxt = seconds_nxt + 6'd1;
        end
        match = (hours_nxt == al_hours_nxt) && (minutes_nxt == al_minutes_nxt) &&
                (seconds_nxt == al_seconds_nxt);
        if (al_en_nxt && !al_fired_r && match) begin
          al_fired_nxt = 1'b1;
          buz_req.ring = 1'b1;
        end else if (al_fired_r && !match) begin
          al_fired_nxt = 1'b0;
        end
      end
    end
  end

  acbs_buzzer u_buzzer (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (in_xfer),
    .req              (buz_req),
    .ticks_per_second (ticks_per_sec_r),
    .tone_half_period (tone_half_r),
    .beep_on_ticks    (beep_on_r),
    .beep_off_ticks   (beep_off_r),
    .pin_nxt          (pin_nxt)
  );

  // Hold clock, alarm and entry state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hours_r      <= 5'd12;
      minutes_r    <= 6'd45;
      seconds_r    <= 6'd0;
      sec_acc_r    <= 16'd0;
      ui_r         <= acbs_pkg::MODE_CLOCK;
      len_r        <= '0;
      al_hours_r   <= 5'd6;
      al_minutes_r <= 6'd0;
      al_seconds_r <= 6'd0;
      al_en_r      <= 1'b1;
      al_fired_r   <= 1'b0;
      fmt24_r      <= 1'b1;
    end else begin
      hours_r      <= hours_nxt;
      minutes_r    <= minutes_nxt;
      seconds_r    <= seconds_nxt;
      sec_acc_r    <= sec_acc_nxt;
      ui_r         <= ui_nxt;
      len_r        <= len_nxt;
      al_hours_r   <= al_hours_nxt;
      al_minutes_r <= al_minutes_nxt;
      al_seconds_r <= al_seconds_nxt;
      al_en_r      <= al_en_nxt;
      al_fired_r   <= al_fired_nxt;
      fmt24_r      <= fmt24_nxt;
    end
  end

  // Entry digits are only read below the entry length
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // Output stage: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_xfer | (out_valid_r & out_stall);
    end
  end

  // Output stage: load the result of each accepted tick
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      digit_r     <= disp;
      buzzer_r    <= pin_nxt;
      ui_out_r    <= ui_nxt;
      alarm_on_r  <= al_en_nxt;
      fmt24_out_r <= fmt24_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_digit_0      = digit_r[0];
  assign out_digit_1      = digit_r[1];
  assign out_digit_2      = digit_r[2];
  assign out_digit_3      = digit_r[3];
  assign out_digit_4      = digit_r[4];
  assign out_digit_5      = digit_r[5];
  assign out_buzzer_level = buzzer_r;
  assign out_ui_mode      = ui_out_r;
  assign out_alarm_on     = alarm_on_r;
  assign out_format_24h   = fmt24_out_r;

endmodule

`default_nettype wire

@@ test/acbs_tick_checker.sv @@
// Scoreboard for the alarm clock core: models every tick and checks each result transfer.
module acbs_tick_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_key_valid,
  input  logic [3:0]  in_key_code,
  input  logic        in_button_press,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_digit_0,
  input  logic [3:0]  out_digit_1,
  input  logic [3:0]  out_digit_2,
  input  logic [3:0]  out_digit_3,
  input  logic [3:0]  out_digit_4,
  input  logic [3:0]  out_digit_5,
  input  logic        out_buzzer_level,
  input  logic [1:0]  out_ui_mode,
  input  logic        out_alarm_on,
  input  logic        out_format_24h,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          outstanding,
  output int          rings_started
);

  localparam int MAX_PRINTED = 40;

  // One display frame as the core presents it after a tick
  typedef struct packed {
    logic [acbs_pkg::ENTRY_DIGITS-1:0][3:0] digits;
    logic                                   buzzer;
    logic [1:0]                             mode;
    logic                                   alarm_on;
    logic                                   fmt24;
  } panel_t;

  // Register copies
  logic [15:0] sec_ticks, beep_len, gap_len;
  logic [7:0]  toggle_ticks;

  // Clock, entry and alarm state
  logic [4:0]         hh, al_hh;
  logic [5:0]         mm, ss, al_mm, al_ss;
  logic [15:0]        sec_acc;
  acbs_pkg::ui_mode_t ui;
  logic [3:0]         entry [acbs_pkg::ENTRY_DIGITS];
  logic [2:0]         entry_len;
  logic               al_en, al_fired, fmt24;

  // Buzzer sequencer state
  acbs_pkg::sounder_mode_t buz;
  logic [7:0]  tone_div;
  logic [1:0]  beeps_due;
  logic        tone_phase;
  logic [15:0] phase_cnt, ring_len;
  logic        pin_lvl;

  panel_t panel_fifo[$];
  int     err_count = 0;
  int     queued = 0;
  int     ring_count = 0;
  int     results_seen = 0;

  assign mismatches    = err_count;
  assign outstanding   = queued;
  assign rings_started = ring_count;

  task automatic note_error(input string what);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("MISMATCH %s", what);
  endtask

  task automatic check_field(input string name, input logic [3:0] got_v, want_v);
    if (got_v !== want_v)
      note_error($sformatf("result %0d: %s is %0d, predicted %0d",
                           results_seen, name, got_v, want_v));
  endtask

  task automatic wipe_entry();
    entry_len = 3'd0;
    foreach (entry[i]) entry[i] = 4'd0;
  endtask

  task automatic silence();
    buz        = acbs_pkg::BUZ_OFF;
    beeps_due  = 2'd0;
    tone_phase = 1'b0;
    phase_cnt  = 16'd0;
    ring_len   = 16'd0;
    pin_lvl    = 1'b0;
  endtask

  task automatic start_beeps(input logic [1:0] n);
    buz        = acbs_pkg::BUZ_BEEP;
    beeps_due  = n;
    tone_phase = 1'b1;
    phase_cnt  = 16'd0;
    tone_div   = 8'd0;
  endtask

  task automatic tone_tick();
    tone_div = tone_div + 8'd1;
    if (tone_div >= toggle_ticks) begin
      tone_div = 8'd0;
      pin_lvl  = ~pin_lvl;
    end
  endtask

  always @(posedge clk) begin
    panel_t      pn, got, want;
    logic [3:0]  key;
    int unsigned eh, em, es, shown_h;
    logic        hit;
    if (!rst_n) begin
      sec_ticks    = 16'd1100;
      toggle_ticks = 8'd3;
      beep_len     = 16'd120;
      gap_len      = 16'd90;
      hh       = 5'd12;
      mm       = 6'd45;
      ss       = 6'd0;
      sec_acc  = 16'd0;
      ui       = acbs_pkg::MODE_CLOCK;
      wipe_entry();
      al_hh    = 5'd6;
      al_mm    = 6'd0;
      al_ss    = 6'd0;
      al_en    = 1'b1;
      al_fired = 1'b0;
      fmt24    = 1'b1;
      silence();
      tone_div = 8'd0;
      panel_fifo.delete();
    end else begin
      // Apply register writes; they only come while no tick is in flight
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          acbs_pkg::REG_TICKS_PER_SEC: sec_ticks    = cfg_data;
          acbs_pkg::REG_TONE_HALF:     toggle_ticks = cfg_data[7:0];
          acbs_pkg::REG_BEEP_ON:       beep_len     = cfg_data;
          acbs_pkg::REG_BEEP_OFF:      gap_len      = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        // Format button first, then the key
        if (in_button_press) begin
          fmt24 = ~fmt24;
          start_beeps(2'd1);
        end
        if (in_key_valid) begin
          key = in_key_code;
          if (ui == acbs_pkg::MODE_CLOCK) begin
            if (key == acbs_pkg::KEY_ALARM_TOG) begin
              al_en = ~al_en;
              start_beeps(2'd1);
              if (!al_en) silence();
            end else if (key == acbs_pkg::KEY_SET_TIME || key == acbs_pkg::KEY_SET_ALARM) begin
              ui = (key == acbs_pkg::KEY_SET_TIME) ? acbs_pkg::MODE_EDIT_TIME
                                                   : acbs_pkg::MODE_EDIT_ALARM;
              wipe_entry();
              start_beeps(2'd1);
            end
          end else if (key == acbs_pkg::KEY_CANCEL) begin
            ui = acbs_pkg::MODE_CLOCK;
            wipe_entry();
            start_beeps(2'd1);
          end else if (key == acbs_pkg::KEY_BACKSPACE) begin
            if (entry_len != 3'd0) entry_len = entry_len - 3'd1;
            start_beeps(2'd1);
          end else if (key <= acbs_pkg::KEY_DIGIT_MAX) begin
            if (entry_len < acbs_pkg::ENTRY_DIGITS) begin
              entry[entry_len] = key;
              entry_len = entry_len + 3'd1;
            end
          end else if (key == acbs_pkg::KEY_CONFIRM) begin
            if (entry_len == acbs_pkg::ENTRY_DIGITS) begin
              eh = entry[0] * 10 + entry[1];
              em = entry[2] * 10 + entry[3];
              es = entry[4] * 10 + entry[5];
              if (eh <= 23 && em <= 59 && es <= 59) begin
                if (ui == acbs_pkg::MODE_EDIT_TIME) begin
                  hh = 5'(eh);
                  mm = 6'(em);
                  ss = 6'(es);
                end else begin
                  al_hh = 5'(eh);
                  al_mm = 6'(em);
                  al_ss = 6'(es);
                  al_en = 1'b1;
                end
                ui = acbs_pkg::MODE_CLOCK;
                wipe_entry();
                start_beeps(2'd2);
              end else begin
                wipe_entry();
                start_beeps(2'd3);
              end
            end else begin
              start_beeps(2'd3);
            end
          end
        end

        // Latch the digits before the buzzer and the clock move
        if (ui != acbs_pkg::MODE_CLOCK) begin
          for (int i = 0; i < acbs_pkg::ENTRY_DIGITS; i++)
            pn.digits[i] = (i < entry_len) ? entry[i] : 4'd0;
        end else begin
          shown_h = hh;
          if (!fmt24) begin
            shown_h = hh % 12;
            if (shown_h == 0) shown_h = 12;
          end
          pn.digits[0] = 4'(shown_h / 10);
          pn.digits[1] = 4'(shown_h % 10);
          pn.digits[2] = 4'(mm / 10);
          pn.digits[3] = 4'(mm % 10);
          pn.digits[4] = 4'(ss / 10);
          pn.digits[5] = 4'(ss % 10);
        end

        // Advance the buzzer sequencer
        if (buz == acbs_pkg::BUZ_RING) begin
          tone_tick();
          ring_len = ring_len + 16'd1;
          if (ring_len >= sec_ticks) silence();
        end else if (buz == acbs_pkg::BUZ_BEEP) begin
          if (beeps_due == 2'd0) begin
            silence();
          end else begin
            phase_cnt = phase_cnt + 16'd1;
            if (tone_phase) begin
              tone_tick();
              if (phase_cnt >= beep_len) begin
                tone_phase = 1'b0;
                phase_cnt  = 16'd0;
                pin_lvl    = 1'b0;
              end
            end else if (phase_cnt >= gap_len) begin
              tone_phase = 1'b1;
              phase_cnt  = 16'd0;
              beeps_due  = beeps_due - 2'd1;
            end
          end
        end

        // Advance the clock in normal mode and fire the alarm on a match
        if (ui == acbs_pkg::MODE_CLOCK) begin
          sec_acc = sec_acc + 16'd1;
          if (sec_acc >= sec_ticks) begin
            sec_acc = 16'd0;
            ss = ss + 6'd1;
            if (ss >= 6'd60) begin
              ss = 6'd0;
              mm = mm + 6'd1;
            end
            if (mm >= 6'd60) begin
              mm = 6'd0;
              hh = hh + 5'd1;
            end
            if (hh >= 5'd24) hh = 5'd0;
            hit = (hh == al_hh) && (mm == al_mm) && (ss == al_ss);
            if (al_en && !al_fired && hit) begin
              al_fired = 1'b1;
              buz      = acbs_pkg::BUZ_RING;
              ring_len = 16'd0;
              tone_div = 8'd0;
              ring_count++;
            end
            if (al_fired && !hit) al_fired = 1'b0;
          end
        end

        pn.buzzer   = pin_lvl;
        pn.mode     = ui;
        pn.alarm_on = al_en;
        pn.fmt24    = fmt24;
        panel_fifo.push_back(pn);
      end

      // Compare each result transfer with the oldest predicted frame
      if (out_valid && !out_stall) begin
        got.digits   = {out_digit_5, out_digit_4, out_digit_3,
                        out_digit_2, out_digit_1, out_digit_0};
        got.buzzer   = out_buzzer_level;
        got.mode     = out_ui_mode;
        got.alarm_on = out_alarm_on;
        got.fmt24    = out_format_24h;
        if (panel_fifo.size() == 0) begin
          note_error($sformatf("result %0d arrived with no tick pending", results_seen));
        end else begin
          want = panel_fifo.pop_front();
          for (int i = 0; i < acbs_pkg::ENTRY_DIGITS; i++)
            check_field($sformatf("digit_%0d", i), got.digits[i], want.digits[i]);
          check_field("buzzer_level", got.buzzer, want.buzzer);
          check_field("ui_mode", got.mode, want.mode);
          check_field("alarm_on", got.alarm_on, want.alarm_on);
          check_field("format_24h", got.fmt24, want.fmt24);
        end
        results_seen++;
      end
    end
    queued = panel_fifo.size();
  end

endmodule

@@ test/tb_top.sv @@
// Testbench top for the alarm clock core: reset, tick stimulus, stall patterns and verdict.
module tb_top;

  localparam int          HALF_PERIOD = 5;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          HOLD_CYCLES = 48;
  localparam int          DRAIN_SLACK = 8;
  localparam int          DIRECTED_TICKS = 20;
  localparam int          PHASE_TICKS = 150;
  localparam int          NUM_PHASES = 9;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_key_valid = 1'b0;
  logic [3:0]  in_key_code = 4'd0;
  logic        in_button_press = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_digit_0, out_digit_1, out_digit_2, out_digit_3, out_digit_4, out_digit_5;
  logic        out_buzzer_level;
  logic [1:0]  out_ui_mode;
  logic        out_alarm_on;
  logic        out_format_24h;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;

  int          mismatches, outstanding, rings_started;
  int          ticks_sent = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_left = 0;
  int          holds_done = 0;
  int          settings_done = 0;
  bit          hold_req = 1'b0;
  int unsigned cycle_count = 0;
  logic [15:0] tps_now = 16'd1100;

  alarm_clock_with_beep_sequencer_core dut (.*);
  acbs_tick_checker checker_i (.*);

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Hard stop if the run hangs
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results still due", cycle_count, outstanding);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: random stalls, plus a long hold whenever one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Offer one tick and hold it until the core takes it; returns at a falling edge
  task automatic send_tick(input logic kv, input logic [3:0] kc, input logic bp);
    if (ticks_sent < 450) begin
      tx_idle_pct = 17;
      rx_idle_pct = 87;
    end else if (ticks_sent < 900) begin
      tx_idle_pct = 87;
      rx_idle_pct = 17;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid    <= 1'b0;
      in_key_code <= 4'($urandom);
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_key_valid    <= kv;
    in_key_code     <= kc;
    in_button_press <= bp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic press(input logic [3:0] k);
    send_tick(1'b1, k, 1'b0);
  endtask

  // Key in a full HHMMSS entry under the given mode key and confirm it
  task automatic key_in_time(input logic [3:0] mode_key, input int h, input int m, input int s);
    press(mode_key);
    press(4'(h / 10));
    press(4'(h % 10));
    press(4'(m / 10));
    press(4'(m % 10));
    press(4'(s / 10));
    press(4'(s % 10));
    press(acbs_pkg::KEY_CONFIRM);
  endtask

  // Plain ticks with an occasional format button or alarm toggle
  task automatic run_ticks(input int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(59);
      if (pick == 0) send_tick(1'b1, acbs_pkg::KEY_ALARM_TOG, 1'b0);
      else send_tick(1'b0, 4'($urandom), pick == 1);
    end
  endtask

  // Stop offering ticks until every predicted result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // Write all four registers back to back while the core is idle
  task automatic load_config(input logic [15:0] tps, half, on_len, off_len);
    logic [15:0] vals [4];
    vals = '{tps, half, on_len, off_len};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    tps_now = tps;
    settings_done++;
  endtask

  initial begin
    int r, n, k, al, st, h, m, s;
    // Hold reset, then release it at a falling edge
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: format button, alarm toggles, ignored keys in normal mode
    send_tick(1'b0, 4'd0, 1'b1);
    press(acbs_pkg::KEY_ALARM_TOG);
    press(acbs_pkg::KEY_ALARM_TOG);
    press(4'd0);
    press(acbs_pkg::KEY_CONFIRM);
    // Set time with backspace on an empty entry and a digit past a full entry
    press(acbs_pkg::KEY_SET_TIME);
    press(acbs_pkg::KEY_BACKSPACE);
    press(4'd2);
    press(4'd3);
    press(4'd5);
    press(4'd9);
    press(4'd5);
    press(4'd9);
    press(4'd9);
    press(acbs_pkg::KEY_CONFIRM);
    // Short confirm, alarm toggle ignored in a set mode, cancel with the button
    press(acbs_pkg::KEY_SET_ALARM);
    press(4'd0);
    press(acbs_pkg::KEY_CONFIRM);
    press(acbs_pkg::KEY_ALARM_TOG);
    send_tick(1'b1, acbs_pkg::KEY_CANCEL, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: load_config(16'd1100, 16'd3, 16'd120, 16'd90);
        1: load_config(16'd1, 16'd1, 16'd1, 16'd1);
        2: load_config(16'd2, 16'd2, 16'd3, 16'd2);
        3: load_config(16'd0, 16'd0, 16'd0, 16'd0);
        4: load_config(16'hFFFF, 16'd255, 16'hFFFF, 16'hFFFF);
        5: load_config(16'd3, {8'($urandom), 8'($urandom_range(4, 1))}, 16'd4, 16'd3);
        6: load_config(16'($urandom_range(6, 1)), 16'($urandom_range(5, 1)),
                       16'($urandom_range(12, 1)), 16'($urandom_range(8, 1)));
        7: load_config(16'd1, 16'd3, 16'd5, 16'd5);
        default: load_config(16'($urandom_range(4, 1)), 16'd255,
                             16'($urandom_range(3, 1)), 16'($urandom_range(3, 1)));
      endcase
      // Back up the result channel while ticks keep coming
      hold_req = 1'b1;

      while (ticks_sent < DIRECTED_TICKS + (p + 1) * PHASE_TICKS) begin
        r = $urandom_range(99);
        if (r < 30) begin
          // Alarm a few seconds ahead of the clock, then let it ring
          al = $urandom_range(86399);
          if ($urandom_range(7) == 0) al = $urandom_range(1) ? 86399 : 0;
          k  = $urandom_range(3, 1);
          st = (al + 86400 - k) % 86400;
          press(acbs_pkg::KEY_CANCEL);
          key_in_time(acbs_pkg::KEY_SET_ALARM, al / 3600, (al / 60) % 60, al % 60);
          key_in_time(acbs_pkg::KEY_SET_TIME, st / 3600, (st / 60) % 60, st % 60);
          n = (k + 2) * ((tps_now == 16'd0) ? 1 : int'(tps_now)) + 4;
          run_ticks((n > 40) ? 40 : n);
        end else if (r < 45) begin
          // Well-formed time set with random content
          if ($urandom_range(1)) press(acbs_pkg::KEY_CANCEL);
          key_in_time(acbs_pkg::KEY_SET_TIME, $urandom_range(23), $urandom_range(59),
                      $urandom_range(59));
        end else if (r < 55) begin
          // Full entry with at least one field out of range
          h = $urandom_range(99);
          m = $urandom_range(99);
          s = $urandom_range(99);
          case ($urandom_range(2))
            0:       h = $urandom_range(99, 24);
            1:       m = $urandom_range(99, 60);
            default: s = $urandom_range(99, 60);
          endcase
          press(acbs_pkg::KEY_CANCEL);
          key_in_time($urandom_range(1) ? acbs_pkg::KEY_SET_TIME : acbs_pkg::KEY_SET_ALARM,
                      h, m, s);
        end else if (r < 75) begin
          // Broken entry: random digits and backspaces, then any closing key
          press($urandom_range(1) ? acbs_pkg::KEY_SET_TIME : acbs_pkg::KEY_SET_ALARM);
          repeat ($urandom_range(8))
            press(($urandom_range(5) == 0) ? acbs_pkg::KEY_BACKSPACE
                                           : 4'($urandom_range(9)));
          case ($urandom_range(3))
            0:       press(acbs_pkg::KEY_CONFIRM);
            1:       press(acbs_pkg::KEY_CANCEL);
            2:       press(acbs_pkg::KEY_ALARM_TOG);
            default: press(4'($urandom_range(15)));
          endcase
        end else if (r < 90) begin
          run_ticks($urandom_range(30, 5));
        end else begin
          // Noise: any key, any button
          repeat ($urandom_range(15, 5))
            send_tick(1'($urandom), 4'($urandom), $urandom_range(7) == 0);
        end
      end
    end

    drain();
    repeat (DRAIN_SLACK) @(negedge clk);

    $display("Run covered %0d ticks under %0d register settings with %0d long output holds,",
             ticks_sent, settings_done, holds_done);
    $display("including %0d alarm rings, entry edits, bad confirms and format toggles.",
             rings_started);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/acbs_pkg.sv
hw/rtl/acbs_buzzer.sv
hw/rtl/alarm_clock_with_beep_sequencer_core.sv
test/acbs_tick_checker.sv
test/tb_top.sv
